/* src/lkvc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
`default_nettype none
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_UPD  = 1'b1
  } state_t;

  // one slot of the recency chain
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } ent_t;

  // request broadcast to every cell
  typedef struct packed {
    logic             cmp_en;
    logic [KEY_W-1:0] cmp_key;
    logic             up_en;
    logic             evict;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* src/lkvc_cell.sv */
// One slot of the recency-ordered chain: key match, shift and stop logic.
`default_nettype none
module lkvc_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lkvc_pkg::cell_ctl_t ctl,
  input  wire lkvc_pkg::ent_t    prev_ent,
  input  wire logic              next_vld,
  input  wire logic              shift_in,
  output lkvc_pkg::ent_t         ent,
  output logic                   shift_out,
  output logic                   hit
);

  logic vld;
  logic [lkvc_pkg::KEY_W-1:0] key;
  logic [lkvc_pkg::VAL_W-1:0] val;
  logic hit_q;
  logic last;
  logic stop;

  assign last = vld && !next_vld;
  // a hit, an empty slot or the evicted tail absorbs the shift
  assign stop = hit_q || !vld || (ctl.evict && last);
  assign shift_out = shift_in && !stop;

  assign ent = '{vld: vld, key: key, val: val};
  assign hit = hit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        hit_q <= vld && (key == ctl.cmp_key);
      end
      if (ctl.up_en && shift_in) begin
        vld <= prev_ent.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.up_en && shift_in) begin
      key <= prev_ent.key;
      val <= prev_ent.val;
    end
  end

endmodule
`default_nettype wire

/* src/lru_key_value_cache_top.sv */
// Top level of the LRU key-value cache: request control and the cell chain.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata = key[31:0], data_in[63:32]; tuser = op
//  m_*      out  m_tvalid/m_tready  tdata = read_value[31:0]; tuser = found
//  cfg_*    in   cfg_we             cfg_wdata = capacity[4:0]
//
// For each request, the accept edge registers the key match in each cell; in the
// update state a set shifts the chain and a get loads the result register.
// Reset empties the chain at once; no clearing pass is needed.
// A get waits in the update cycle while an earlier result has not been taken;
// a set never waits on the result side.
`default_nettype none
module lru_key_value_cache_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // key[31:0], data_in[63:32]
  input  wire logic [0:0]  s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // read_value[31:0]
  output logic [0:0]       m_tuser,   // found
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW    = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  lkvc_pkg::state_t state, state_next;

  logic [lkvc_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]           count;
  lkvc_pkg::op_t              req_op;
  logic [lkvc_pkg::KEY_W-1:0] req_key;
  logic [lkvc_pkg::VAL_W-1:0] req_data;

  logic s_acc;
  logic up_en;
  logic [CW-1:0] cap_eff;
  logic evict;
  logic hit_any;
  logic [lkvc_pkg::VAL_W-1:0] hit_val;

  lkvc_pkg::cell_ctl_t ctl;
  lkvc_pkg::ent_t      ents [ENTRIES];
  lkvc_pkg::ent_t      prevs [ENTRIES];
  logic [ENTRIES:0]    shift;
  logic [ENTRIES-1:0]  hits;
  logic [ENTRIES-1:0]  next_vlds;

  assign s_acc = s_tvalid && s_tready;

  always_comb begin
    cap_eff = CW'(capacity);
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(capacity) > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
  end

  assign evict = CW'(count) >= cap_eff;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    up_en      = 1'b0;
    case (state)
      lkvc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = lkvc_pkg::ST_UPD;
        end
      end
      lkvc_pkg::ST_UPD: begin
        // hold a get until the result register is free
        up_en = (req_op == lkvc_pkg::OP_SET) || !m_tvalid || m_tready;
        if (up_en) begin
          state_next = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      req_op   <= lkvc_pkg::op_t'(s_tuser[0]);
      req_key  <= s_tdata[31:0];
      req_data <= s_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign ctl = '{cmp_en: s_acc, cmp_key: s_tdata[31:0], up_en: up_en, evict: evict};

  assign shift[0] = (req_op == lkvc_pkg::OP_SET);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prevs[i] = '{vld: 1'b1, key: req_key, val: req_data};
    end else begin : g_body
      assign prevs[i] = ents[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign next_vlds[i] = 1'b0;
    end else begin : g_mid
      assign next_vlds[i] = ents[i+1].vld;
    end

    lkvc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev_ent  (prevs[i]),
      .next_vld  (next_vlds[i]),
      .shift_in  (shift[i]),
      .ent       (ents[i]),
      .shift_out (shift[i+1]),
      .hit       (hits[i])
    );
  end

  assign hit_any = |hits;

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val = hit_val | (ents[i].val & {lkvc_pkg::VAL_W{hits[i]}});
    end
  end

  // grow the count only on an insert that evicts nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (up_en && (req_op == lkvc_pkg::OP_SET) && !hit_any && !evict) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (up_en && (req_op == lkvc_pkg::OP_GET)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_en && (req_op == lkvc_pkg::OP_GET)) begin
      m_tuser[0] <= hit_any;
      m_tdata    <= hit_any ? hit_val : lkvc_pkg::MISS_VALUE;
    end
  end

endmodule
`default_nettype wire

/* src/lkvc_checker.sv */
// Port-level checks for the LRU key-value cache, bound to the top level.
`default_nettype none
module lkvc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a miss always reads as all ones
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 32'hFFFF_FFFF)
    else $error("miss result is not all ones");

  // an accepted item keeps the input closed for the update cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready during update cycle");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
